FILE: design/hbsd_pkg.sv
// Shared types and constants for the bit-serial Huffman decoder.
// No dependencies; every other design file refers to this package by scoped names.
`default_nettype none

package hbsd_pkg;

  // Field widths of the channels.
  localparam int SYM_W    = 8;
  localparam int COUNT_W  = 32;
  localparam int STATUS_W = 2;

  // Size of the symbol alphabet; leaf symbols at or above it are malformed.
  localparam int ALPHABET = 256;

  // Default storage sizes handed to the top level.
  localparam int NODE_DEPTH_DEF  = 512;
  localparam int STACK_DEPTH_DEF = 256;

  // Stream phase.
  typedef enum logic [2:0] {
    PH_NODE,
    PH_SYM,
    PH_DECODE,
    PH_DONE,
    PH_BAD
  } phase_e;

  // Status codes carried with each result beat.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_TRUNC,
    ST_MALFORMED
  } status_e;

  // One result beat.
  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
    status_e          status;
  } res_t;

endpackage

`default_nettype wire

FILE: design/hbsd_if.sv
// Valid/ready channel interfaces of the decoder: stream bits, decoded symbols, configuration.
// Depends on hbsd_pkg for the field widths.
`default_nettype none

// Compressed stream input, one bit per beat.
interface hbsd_bit_if;
  logic valid;
  logic ready;
  logic bit_req;
  logic stream_end;

  modport source (output valid, output bit_req, output stream_end, input ready);
  modport sink   (input valid, input bit_req, input stream_end, output ready);
endinterface

// Decoded symbol output, one result per beat.
interface hbsd_sym_if;
  logic                            valid;
  logic                            ready;
  logic [hbsd_pkg::SYM_W-1:0]      symbol;
  logic                            last;
  logic [hbsd_pkg::STATUS_W-1:0]   status;

  modport source (output valid, output symbol, output last, output status, input ready);
  modport sink   (input valid, input symbol, input last, input status, output ready);
endinterface

// Configuration write channel for the symbol count register.
interface hbsd_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [hbsd_pkg::COUNT_W-1:0] symbol_count;

  modport source (output valid, output symbol_count, input ready);
  modport sink   (input valid, input symbol_count, output ready);
endinterface

`default_nettype wire

FILE: design/hbsd_out_queue.sv
// Two-beat output queue between the decoder core and the symbol channel.
// Depends on hbsd_pkg (res_t) and hbsd_if (hbsd_sym_if).
`default_nettype none

module hbsd_out_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire hbsd_pkg::res_t push_data_i,
  output logic                room_o,
  hbsd_sym_if.source          out_ch
);

  hbsd_pkg::res_t head_q, head_d;
  hbsd_pkg::res_t skid_q, skid_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           pop;

  // The head slot drives the channel; the skid slot holds a second beat.
  assign out_ch.valid  = (cnt_q != 2'd0);
  assign out_ch.symbol = head_q.symbol;
  assign out_ch.last   = head_q.last;
  assign out_ch.status = head_q.status;
  assign room_o        = (cnt_q != 2'd2);

  assign pop = (cnt_q != 2'd0) && out_ch.ready;

  // Shift the skid slot forward on a pop and place a new beat in the first free slot.
  always_comb begin
    head_d = head_q;
    skid_d = skid_q;
    if (pop) begin
      head_d = skid_q;
    end
    if (push_i) begin
      if (cnt_q == 2'd0 || (cnt_q == 2'd1 && pop)) begin
        head_d = push_data_i;
      end else begin
        skid_d = push_data_i;
      end
    end
    cnt_d = cnt_q + 2'(push_i) - 2'(pop);
  end

  // Occupancy count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Payload slots.
  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

endmodule

`default_nettype wire

FILE: design/huffman_bit_serial_decoder.sv
// Top level of the bit-serial Huffman decoder with a preorder tree header.
// Depends on hbsd_pkg, hbsd_if and hbsd_out_queue.
//
//   channel  dir  beat content                    handshake
//   in_ch    in   bit_req, stream_end             valid/ready
//   out_ch   out  symbol, last, status            valid/ready
//   cfg_ch   in   symbol_count                    valid/ready (ready always high)
//
// Each input beat is handled in an accept cycle, which reads the node memories and the
// parent stack memory, then an update cycle, marked by busy_q, which uses the read data
// and writes back. No beat is accepted while busy_q is set; that loop sets the rate.
// Reset clears the control state only; the node and stack memories need no
// clearing pass, since only entries written in the current stream are ever read.
// Results go through a two-beat queue, so input keeps flowing while one result
// waits; input stalls only in update cycles or when both queue slots are full.
`default_nettype none

module huffman_bit_serial_decoder #(
  parameter int NODE_DEPTH  = hbsd_pkg::NODE_DEPTH_DEF,
  parameter int STACK_DEPTH = hbsd_pkg::STACK_DEPTH_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  hbsd_bit_if.sink   in_ch,
  hbsd_sym_if.source out_ch,
  hbsd_cfg_if.sink   cfg_ch
);

  localparam int NW  = $clog2(NODE_DEPTH);
  localparam int NTW = $clog2(NODE_DEPTH + 1);
  localparam int SW  = $clog2(STACK_DEPTH);
  localparam int STW = $clog2(STACK_DEPTH + 1);
  localparam int CW  = hbsd_pkg::COUNT_W;
  localparam int YW  = hbsd_pkg::SYM_W;
  localparam logic [YW:0] ALPHA_LIM = (YW + 1)'(hbsd_pkg::ALPHABET);

  // Control state.
  hbsd_pkg::phase_e phase_q, phase_d;
  logic             busy_q;
  logic [STW-1:0]   top_q, top_d;
  logic [NTW-1:0]   total_q, total_d;
  logic [YW-1:0]    shift_q, shift_d;
  logic [2:0]       sbit_cnt_q, sbit_cnt_d;
  logic             at_root_q, at_root_d;
  logic [CW-1:0]    emitted_q, emitted_d;
  logic [CW-1:0]    count_q;

  // Payload state: current beat, cached root node, current node children, stack top.
  logic             bit_q, end_q;
  logic             root_leaf_q, root_leaf_d;
  logic [YW-1:0]    root_sym_q, root_sym_d;
  logic [NW-1:0]    root_left_q, root_left_d;
  logic [NW-1:0]    root_right_q, root_right_d;
  logic [NW-1:0]    cur_left_q, cur_left_d;
  logic [NW-1:0]    cur_right_q, cur_right_d;
  logic [NW-1:0]    tos_idx_q, tos_idx_d;
  logic             tos_left_q, tos_left_d;

  // Memories and their registered read data.
  logic             leaf_mem  [NODE_DEPTH];
  logic [YW-1:0]    sym_mem   [NODE_DEPTH];
  logic [NW-1:0]    left_mem  [NODE_DEPTH];
  logic [NW-1:0]    right_mem [NODE_DEPTH];
  logic [NW:0]      stk_mem   [STACK_DEPTH];
  logic             leaf_rd_q;
  logic [YW-1:0]    sym_rd_q;
  logic [NW-1:0]    left_rd_q, right_rd_q;
  logic [NW:0]      stk_rd_q;

  // Write ports.
  logic             leaf_we, sym_we, left_we, right_we, stk_we;
  logic [NW-1:0]    leaf_wa, sym_wa, lr_wa, lr_wd;
  logic             leaf_wd;
  logic [YW-1:0]    sym_wd;
  logic [SW-1:0]    stk_wa;
  logic [NW:0]      stk_wd;

  // Handshake and result.
  logic             accept, room;
  logic             res_push;
  hbsd_pkg::res_t   res;

  // Shared conditions of the update cycle.
  logic [NW-1:0]    walk_addr;
  logic [STW-1:0]   top_m1, top_m2, top_after_pop;
  logic [NW-1:0]    new_idx, sym_idx;
  logic [NTW-1:0]   total_m1;
  logic             node_full, pop, stack_full;
  logic [YW-1:0]    sym_next;
  logic             sym_done, sym_bad;
  logic             count_reached, walk_emit, last_hit;
  logic [CW-1:0]    emitted_inc;

  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = !busy_q && room;
  assign cfg_ch.ready = 1'b1;

  // Child chosen by the incoming bit from the current node (the root after a leaf).
  always_comb begin
    if (in_ch.bit_req) begin
      walk_addr = at_root_q ? root_right_q : cur_right_q;
    end else begin
      walk_addr = at_root_q ? root_left_q : cur_left_q;
    end
  end

  assign top_m1        = top_q - STW'(1);
  assign top_m2        = top_q - STW'(2);
  assign pop           = (top_q != '0) && tos_left_q;
  assign top_after_pop = top_q - STW'(pop);
  assign node_full     = (total_q >= NTW'(NODE_DEPTH));
  assign stack_full    = (top_after_pop >= STW'(STACK_DEPTH));
  assign new_idx       = total_q[NW-1:0];
  assign total_m1      = total_q - NTW'(1);
  assign sym_idx       = total_m1[NW-1:0];
  assign sym_next      = {shift_q[YW-2:0], bit_q};
  assign sym_done      = (sbit_cnt_q == 3'd7);
  assign sym_bad       = ({1'b0, sym_next} >= ALPHA_LIM);
  assign count_reached = (emitted_q >= count_q);
  assign emitted_inc   = emitted_q + CW'(1);
  assign last_hit      = (emitted_inc >= count_q);
  assign walk_emit     = root_leaf_q || leaf_rd_q;

  // Next phase, decided in the update cycle of each beat.
  always_comb begin
    phase_d = phase_q;
    if (busy_q) begin
      if (end_q) begin
        phase_d = hbsd_pkg::PH_NODE;
      end else begin
        case (phase_q)
          hbsd_pkg::PH_NODE: begin
            if (node_full) begin
              phase_d = hbsd_pkg::PH_BAD;
            end else if (bit_q) begin
              phase_d = hbsd_pkg::PH_SYM;
            end else if (stack_full) begin
              phase_d = hbsd_pkg::PH_BAD;
            end
          end
          hbsd_pkg::PH_SYM: begin
            if (sym_done) begin
              if (sym_bad) begin
                phase_d = hbsd_pkg::PH_BAD;
              end else if (top_q != '0) begin
                phase_d = hbsd_pkg::PH_NODE;
              end else if (count_reached) begin
                phase_d = hbsd_pkg::PH_DONE;
              end else begin
                phase_d = hbsd_pkg::PH_DECODE;
              end
            end
          end
          hbsd_pkg::PH_DECODE: begin
            if (count_reached || (walk_emit && last_hit)) begin
              phase_d = hbsd_pkg::PH_DONE;
            end
          end
          default: phase_d = phase_q;
        endcase
      end
    end
  end

  // Datapath updates, memory writes and results of the update cycle.
  always_comb begin
    top_d        = top_q;
    total_d      = total_q;
    shift_d      = shift_q;
    sbit_cnt_d   = sbit_cnt_q;
    at_root_d    = at_root_q;
    emitted_d    = emitted_q;
    root_leaf_d  = root_leaf_q;
    root_sym_d   = root_sym_q;
    root_left_d  = root_left_q;
    root_right_d = root_right_q;
    cur_left_d   = cur_left_q;
    cur_right_d  = cur_right_q;
    tos_idx_d    = tos_idx_q;
    tos_left_d   = tos_left_q;
    leaf_we      = 1'b0;
    leaf_wa      = new_idx;
    leaf_wd      = bit_q;
    sym_we       = 1'b0;
    sym_wa       = sym_idx;
    sym_wd       = sym_next;
    left_we      = 1'b0;
    right_we     = 1'b0;
    lr_wa        = tos_idx_q;
    lr_wd        = new_idx;
    stk_we       = 1'b0;
    stk_wa       = top_m1[SW-1:0];
    stk_wd       = {1'b1, tos_idx_q};
    res_push     = 1'b0;
    res.symbol   = '0;
    res.last     = 1'b1;
    res.status   = hbsd_pkg::ST_MALFORMED;

    if (busy_q) begin
      if (end_q) begin
        // End of stream: rearm, and flag truncation unless the stream had finished or was malformed.
        top_d      = '0;
        total_d    = '0;
        shift_d    = '0;
        sbit_cnt_d = '0;
        at_root_d  = 1'b1;
        emitted_d  = '0;
        if (phase_q != hbsd_pkg::PH_DONE && phase_q != hbsd_pkg::PH_BAD) begin
          res_push   = 1'b1;
          res.status = hbsd_pkg::ST_TRUNC;
        end
      end else begin
        case (phase_q)
          hbsd_pkg::PH_NODE: begin
            if (node_full) begin
              res_push = 1'b1;
            end else begin
              // Record the new node and link it under the parent on top of the stack.
              total_d = total_q + NTW'(1);
              leaf_we = 1'b1;
              if (new_idx == '0) begin
                root_leaf_d = bit_q;
              end
              if (top_q != '0) begin
                if (tos_left_q) begin
                  right_we = 1'b1;
                  if (tos_idx_q == '0) begin
                    root_right_d = new_idx;
                  end
                end else begin
                  left_we    = 1'b1;
                  tos_left_d = 1'b1;
                  if (tos_idx_q == '0) begin
                    root_left_d = new_idx;
                  end
                end
              end
              // A parent with both children leaves the stack.
              if (pop) begin
                top_d      = top_m1;
                tos_idx_d  = stk_rd_q[NW-1:0];
                tos_left_d = stk_rd_q[NW];
              end
              if (bit_q) begin
                shift_d    = '0;
                sbit_cnt_d = '0;
              end else if (stack_full) begin
                res_push = 1'b1;
              end else begin
                // Internal node becomes the new stack top; an old top that was not popped spills to memory.
                top_d      = top_after_pop + STW'(1);
                tos_idx_d  = new_idx;
                tos_left_d = 1'b0;
                stk_we     = (top_q != '0) && !pop;
              end
            end
          end
          hbsd_pkg::PH_SYM: begin
            // Collect the leaf symbol, MSB first.
            shift_d = sym_next;
            if (!sym_done) begin
              sbit_cnt_d = sbit_cnt_q + 3'd1;
            end else begin
              sbit_cnt_d = '0;
              if (sym_bad) begin
                res_push = 1'b1;
              end else begin
                sym_we = 1'b1;
                if (sym_idx == '0) begin
                  root_sym_d = sym_next;
                end
                if (top_q == '0) begin
                  at_root_d = 1'b1;
                end
              end
            end
          end
          hbsd_pkg::PH_DECODE: begin
            // One step down the tree; a leaf emits its symbol and returns to the root.
            if (!count_reached) begin
              if (walk_emit) begin
                emitted_d  = emitted_inc;
                at_root_d  = 1'b1;
                res_push   = 1'b1;
                res.symbol = root_leaf_q ? root_sym_q : sym_rd_q;
                res.last   = last_hit;
                res.status = hbsd_pkg::ST_OK;
              end else begin
                cur_left_d  = left_rd_q;
                cur_right_d = right_rd_q;
                at_root_d   = 1'b0;
              end
            end
          end
          default: res_push = 1'b0;
        endcase
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= hbsd_pkg::PH_NODE;
      busy_q     <= 1'b0;
      top_q      <= '0;
      total_q    <= '0;
      shift_q    <= '0;
      sbit_cnt_q <= '0;
      at_root_q  <= 1'b1;
      emitted_q  <= '0;
      count_q    <= '0;
    end else begin
      phase_q    <= phase_d;
      busy_q     <= accept;
      top_q      <= top_d;
      total_q    <= total_d;
      shift_q    <= shift_d;
      sbit_cnt_q <= sbit_cnt_d;
      at_root_q  <= at_root_d;
      emitted_q  <= emitted_d;
      if (cfg_ch.valid) begin
        count_q <= cfg_ch.symbol_count;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      bit_q <= in_ch.bit_req;
      end_q <= in_ch.stream_end;
    end
    root_leaf_q  <= root_leaf_d;
    root_sym_q   <= root_sym_d;
    root_left_q  <= root_left_d;
    root_right_q <= root_right_d;
    cur_left_q   <= cur_left_d;
    cur_right_q  <= cur_right_d;
    tos_idx_q    <= tos_idx_d;
    tos_left_q   <= tos_left_d;
  end

  // Node memories: read at the walk address when a beat is accepted, written back later.
  always_ff @(posedge clk_i) begin
    if (leaf_we) begin
      leaf_mem[leaf_wa] <= leaf_wd;
    end
    if (accept) begin
      leaf_rd_q <= leaf_mem[walk_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sym_we) begin
      sym_mem[sym_wa] <= sym_wd;
    end
    if (accept) begin
      sym_rd_q <= sym_mem[walk_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (left_we) begin
      left_mem[lr_wa] <= lr_wd;
    end
    if (accept) begin
      left_rd_q <= left_mem[walk_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (right_we) begin
      right_mem[lr_wa] <= lr_wd;
    end
    if (accept) begin
      right_rd_q <= right_mem[walk_addr];
    end
  end

  // Parent stack below the cached top entry; the entry under the top is prefetched.
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    if (accept) begin
      stk_rd_q <= stk_mem[top_m2[SW-1:0]];
    end
  end

  // Output queue.
  hbsd_out_queue u_out_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_push),
    .push_data_i (res),
    .room_o      (room),
    .out_ch      (out_ch)
  );

  // Results appear only in the update cycle of an accepted beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_push |-> busy_q)
    else $error("result produced outside an update cycle");

  // The tree is complete, so the parent stack is empty, whenever decoding runs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == hbsd_pkg::PH_DECODE) |-> (top_q == '0))
    else $error("parent stack not empty in decode phase");

  // The stack never grows past its depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) top_q <= STW'(STACK_DEPTH))
    else $error("parent stack overflow");

  // A header node beat that fits adds exactly one node.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !end_q && phase_q == hbsd_pkg::PH_NODE && !node_full)
      |=> (total_q == $past(total_q) + NTW'(1)))
    else $error("node count did not advance on a header node");

endmodule

`default_nettype wire
